/* design/y2r_pkg.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter package
// Word types and fixed-point constants shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned FracW  = 8;
  // Widest chroma term is 454 * 128 = 58112, which needs 17 signed bits.
  localparam int unsigned TermW  = 17;
  // Luma scaled by 256 plus the widest term stays below 2**17.
  localparam int unsigned SumW   = 18;

  localparam logic signed [TermW-1:0] RedVCoef   = 17'sd359;
  localparam logic signed [TermW-1:0] GreenUCoef = 17'sd88;
  localparam logic signed [TermW-1:0] GreenVCoef = 17'sd183;
  localparam logic signed [TermW-1:0] BlueUCoef  = 17'sd454;

  // One packed macropixel as it arrives.
  typedef struct packed {
    logic [ChanW-1:0] luma_first;
    logic [ChanW-1:0] chroma_blue;
    logic [ChanW-1:0] luma_second;
    logic [ChanW-1:0] chroma_red;
    logic             single_pixel;
  } yuyv_word_t;

  // One output pixel.
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             last_of_run;
  } rgb_word_t;

  // Queue entry: both lumas plus the chroma terms shared by the two pixels.
  typedef struct packed {
    logic [ChanW-1:0]        luma_first;
    logic [ChanW-1:0]        luma_second;
    logic                    single_pixel;
    logic signed [TermW-1:0] red_term;
    logic signed [TermW-1:0] green_term;
    logic signed [TermW-1:0] blue_term;
  } y2r_job_t;

endpackage

`default_nettype wire

/* design/y2r_front.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter front end
// Accepts macropixels, removes the chroma offset and forms the chroma terms.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_front (
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire y2r_pkg::yuyv_word_t in_data_i,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i,
  output y2r_pkg::y2r_job_t        push_data_o
);
  import y2r_pkg::*;

  logic signed [ChanW-1:0] u_s, v_s;
  logic signed [TermW-1:0] u_ext, v_ext;

  // Subtracting 128 from an unsigned byte is the same as flipping its top bit
  // and reading it as two's complement.
  assign u_s   = signed'({~in_data_i.chroma_blue[ChanW-1], in_data_i.chroma_blue[ChanW-2:0]});
  assign v_s   = signed'({~in_data_i.chroma_red[ChanW-1], in_data_i.chroma_red[ChanW-2:0]});
  assign u_ext = TermW'(u_s);
  assign v_ext = TermW'(v_s);

  always_comb begin
    push_data_o.luma_first   = in_data_i.luma_first;
    push_data_o.luma_second  = in_data_i.luma_second;
    push_data_o.single_pixel = in_data_i.single_pixel;
    push_data_o.red_term     = TermW'(v_ext * RedVCoef);
    push_data_o.green_term   = TermW'(-(u_ext * GreenUCoef) - (v_ext * GreenVCoef));
    push_data_o.blue_term    = TermW'(u_ext * BlueUCoef);
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

`default_nettype wire

/* design/y2r_queue.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter job queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire y2r_pkg::y2r_job_t  push_data_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output y2r_pkg::y2r_job_t       pop_data_o
);
  import y2r_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  y2r_job_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop, full;

  assign full         = (count_q == CntW'(Depth));
  assign push_ready_o = !full;
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !full;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* design/y2r_back.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter back end
// Expands each job into one or two pixels, adds luma, shifts and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire y2r_pkg::y2r_job_t  job_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output y2r_pkg::rgb_word_t      out_data_o
);
  import y2r_pkg::*;

  // Luma * 256 + term, floor-shifted by eight and clamped to one byte.
  function automatic logic [ChanW-1:0] chan_out(logic [ChanW-1:0] luma,
                                                logic signed [TermW-1:0] term);
    logic signed [SumW-1:0]       sum;
    logic signed [SumW-FracW-1:0] shifted;
    logic [ChanW-1:0]             res;
    sum     = signed'({2'b00, luma, {FracW{1'b0}}}) + SumW'(term);
    shifted = sum[SumW-1:FracW];
    if (shifted[SumW-FracW-1]) begin
      res = '0;
    end else if (|shifted[SumW-FracW-2:ChanW]) begin
      res = '1;
    end else begin
      res = shifted[ChanW-1:0];
    end
    return res;
  endfunction

  logic             phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  rgb_word_t        out_data_q, out_data_d;
  logic             load, last;
  logic [ChanW-1:0] luma;

  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign last        = job_data_i.single_pixel || phase_q;
  assign luma        = phase_q ? job_data_i.luma_second : job_data_i.luma_first;
  assign job_ready_o = load && last;

  always_comb begin
    out_data_d.red         = chan_out(luma, job_data_i.red_term);
    out_data_d.green       = chan_out(luma, job_data_i.green_term);
    out_data_d.blue        = chan_out(luma, job_data_i.blue_term);
    out_data_d.last_of_run = last;
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (load) begin
      phase_d     = !last;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // While the second pixel is pending, its job must still sit at the queue head.
  a_second_pixel_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (job_valid_i && !job_data_i.single_pixel))
    else $error("second pixel pending without a full job at the queue head");

  // A first pixel that is not the last one is always followed by the second.
  a_first_pixel_sets_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.last_of_run) |-> phase_q)
    else $error("first pixel shown without second pixel pending");

  // Retiring a job always puts its final pixel in the output register.
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_i && job_ready_o) |=> (out_valid_q && out_data_q.last_of_run && !phase_q))
    else $error("job retired without a final pixel");

endmodule

`default_nettype wire

/* design/yuyv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// YUYV to RGB converter
// Turns packed YUYV 4:2:2 macropixels into a stream of RGB888 pixels.
// ----------------------------------------------------------------------------
// Each accepted word yields two pixels, first then second, sharing the chroma
// of the word; with single_pixel set only the first pixel comes out. The
// output side gives one pixel per cycle while a job waits and the receiver
// is ready, so a full macropixel occupies the back end for both its pixels
// and an odd-tail word for its one pixel. The front end forms the chroma
// products combinationally and the job queue stores them when the word is
// accepted; from the queue head the back end adds luma, shifts and clamps
// into the output register. The queue lets the input side keep accepting
// while a pixel waits at the output.
`default_nettype none

module yuyv_to_rgb_converter #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire y2r_pkg::yuyv_word_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output y2r_pkg::rgb_word_t       out_data_o
);
  import y2r_pkg::*;

  logic     push_valid, push_ready;
  y2r_job_t push_data;
  logic     job_valid, job_ready;
  y2r_job_t job_data;

  y2r_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  y2r_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (job_valid),
    .pop_ready_i  (job_ready),
    .pop_data_o   (job_data)
  );

  y2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_data_i  (job_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// YUYV to RGB converter testbench
// Feeds packed macropixels through the converter under random back-pressure,
// predicts each RGB pixel in fixed point and checks the output stream in order.
// ----------------------------------------------------------------------------
module tb_top;
  import y2r_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomWords = 150;
  localparam int unsigned HoldAt      = 380;
  localparam int unsigned HoldCycles  = 64;
  localparam int          ChromaBias  = 128;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready_o;
  yuyv_word_t in_data     = '0;
  logic       out_valid_o;
  logic       out_ready   = 1'b0;
  rgb_word_t  out_data_o;

  yuyv_word_t  yuyv_backlog[$];
  rgb_word_t   pending_pixels[$];
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned words_taken       = 0;
  int unsigned hold_left         = 0;
  bit          hold_done         = 1'b0;
  int unsigned mismatch_cnt      = 0;
  int unsigned cycle_cnt         = 0;

  yuyv_to_rgb_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] clamp_chan(int sum);
    int scaled;
    // Arithmetic shift on a signed int rounds towards minus infinity.
    scaled = sum >>> 8;
    if (scaled < 0) return 8'd0;
    if (scaled > 255) return 8'd255;
    return scaled[7:0];
  endfunction

  function automatic rgb_word_t convert_pixel(logic [7:0] luma, int u, int v, logic last);
    rgb_word_t px;
    int        y;
    y = int'(luma) * 256;
    px.red         = clamp_chan(y + 359 * v);
    px.green       = clamp_chan(y - 88 * u - 183 * v);
    px.blue        = clamp_chan(y + 454 * u);
    px.last_of_run = last;
    return px;
  endfunction

  task automatic expect_pixel(rgb_word_t px);
    pending_pixels = {pending_pixels, px};
  endtask

  task automatic add_word(yuyv_word_t w);
    yuyv_backlog = {yuyv_backlog, w};
  endtask

  task automatic queue_macropixel_pixels(yuyv_word_t w);
    int u;
    int v;
    u = int'(w.chroma_blue) - ChromaBias;
    v = int'(w.chroma_red) - ChromaBias;
    if (w.single_pixel) begin
      expect_pixel(convert_pixel(w.luma_first, u, v, 1'b1));
    end else begin
      expect_pixel(convert_pixel(w.luma_first, u, v, 1'b0));
      expect_pixel(convert_pixel(w.luma_second, u, v, 1'b1));
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic yuyv_word_t make_word(logic [7:0] y0, logic [7:0] u, logic [7:0] y1,
                                           logic [7:0] v, logic single);
    yuyv_word_t w;
    w.luma_first   = y0;
    w.chroma_blue  = u;
    w.luma_second  = y1;
    w.chroma_red   = v;
    w.single_pixel = single;
    return w;
  endfunction

  function automatic yuyv_word_t random_macropixel();
    yuyv_word_t w;
    w = make_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom_range(3) == 0);
    // Saturated chroma now and then, so that clamping at both ends is common.
    if ($urandom_range(7) == 0) w.chroma_blue = $urandom_range(1) ? 8'hff : 8'h00;
    if ($urandom_range(7) == 0) w.chroma_red  = $urandom_range(1) ? 8'hff : 8'h00;
    return w;
  endfunction

  task automatic drain_all();
    while (yuyv_backlog.size() != 0 || in_valid || pending_pixels.size() != 0)
      @(negedge clk_i);
  endtask

  // Sender: a word stays on the bus until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready_o) begin
        queue_macropixel_pixels(in_data);
        words_taken <= words_taken + 1;
      end
      if (!in_valid || in_ready_o) begin
        if (yuyv_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_data  <= yuyv_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each pixel taken and decides ready for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_word_t exp_px;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: pixel %h arrived with nothing expected", $time, out_data_o);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          exp_px = pending_pixels.pop_front();
          if (out_data_o.red !== exp_px.red)
            $display("%0t: red expected %0d got %0d", $time, exp_px.red, out_data_o.red);
          if (out_data_o.green !== exp_px.green)
            $display("%0t: green expected %0d got %0d", $time, exp_px.green,
                     out_data_o.green);
          if (out_data_o.blue !== exp_px.blue)
            $display("%0t: blue expected %0d got %0d", $time, exp_px.blue, out_data_o.blue);
          if (out_data_o.last_of_run !== exp_px.last_of_run)
            $display("%0t: last_of_run expected %0b got %0b", $time, exp_px.last_of_run,
                     out_data_o.last_of_run);
          if (out_data_o !== exp_px) mismatch_cnt <= mismatch_cnt + 1;
        end
      end
      // One long hold-off while the sender keeps offering, to fill the converter.
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && words_taken >= HoldAt) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    sender_idle_pct   = 26;
    receiver_idle_pct = 50;
    // Corners: black, white, grey, chroma at both ends, and odd-tail words.
    add_word(make_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    add_word(make_word(8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
    add_word(make_word(8'h00, 8'h80, 8'hff, 8'h80, 1'b0));
    add_word(make_word(8'h80, 8'h80, 8'h80, 8'h80, 1'b0));
    add_word(make_word(8'hff, 8'h00, 8'h00, 8'hff, 1'b0));
    add_word(make_word(8'h00, 8'hff, 8'hff, 8'h00, 1'b0));
    add_word(make_word(8'h10, 8'h80, 8'heb, 8'h80, 1'b0));
    add_word(make_word(8'h80, 8'h00, 8'h80, 8'h00, 1'b0));
    add_word(make_word(8'h80, 8'hff, 8'h80, 8'hff, 1'b0));
    add_word(make_word(8'h01, 8'h7f, 8'hfe, 8'h81, 1'b0));
    add_word(make_word(8'h00, 8'h00, 8'hff, 8'h00, 1'b1));
    add_word(make_word(8'hff, 8'hff, 8'h00, 8'hff, 1'b1));
    add_word(make_word(8'h55, 8'haa, 8'haa, 8'h55, 1'b1));
    add_word(make_word(8'haa, 8'h55, 8'h55, 8'haa, 1'b0));
    add_word(make_word(8'h80, 8'h80, 8'h3c, 8'h80, 1'b1));
    repeat (RandomWords) add_word(random_macropixel());
    drain_all();

    sender_idle_pct   = 50;
    receiver_idle_pct = 26;
    repeat (RandomWords) add_word(random_macropixel());
    drain_all();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (RandomWords) add_word(random_macropixel());
    drain_all();

    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/y2r_pkg.sv
design/y2r_front.sv
design/y2r_queue.sv
design/y2r_back.sv
design/yuyv_to_rgb_converter.sv
bench/tb_top.sv
